[src/rmh_pkg.sv]
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared constants and types for the running median block.
// ----------------------------------------------------------------------------
package rmh_pkg;

    localparam int HEAP_DEPTH_DEF  = 512;
    localparam int SAMPLE_BITS_DEF = 32;

    // Command from the sequencer to one heap chain
    typedef struct packed {
        logic push;
        logic pop;
    } heap_cmd_t;

endpackage

[src/rmh_cell.sv]
// ----------------------------------------------------------------------------
// rmh_cell
// One slot of a sorted chain. Takes the new value, its upper neighbor's value
// on an insert, or its lower neighbor's value on a pop.
// ----------------------------------------------------------------------------
module rmh_cell #(
    parameter int W      = 32,
    parameter bit IS_MAX = 1'b1
) (
    input  logic         clk,
    input  logic         push,
    input  logic         pop,
    input  logic         occupied,
    input  logic [W-1:0] new_val,
    input  logic [W-1:0] prev_val,
    input  logic         prev_ins,
    input  logic [W-1:0] next_val,
    output logic [W-1:0] val,
    output logic         ins
);
    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;
    logic         above;

    // New value belongs at or before this slot
    assign above = IS_MAX ? ($signed(new_val) > $signed(val_reg))
                          : ($signed(new_val) < $signed(val_reg));
    assign ins   = !occupied || above;
    assign val   = val_reg;

    // Select the next slot content
    always_comb
    begin
        val_next = val_reg;
        if (pop)
        begin
            val_next = next_val;
        end
        else if (push && ins)
        begin
            val_next = prev_ins ? prev_val : new_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[src/rmh_heap.sv]
// ----------------------------------------------------------------------------
// rmh_heap
// Priority chain of cells kept in order, best value in slot zero, with a
// fill count. Push inserts a value in order, pop shifts out the top.
// ----------------------------------------------------------------------------
module rmh_heap #(
    parameter int DEPTH  = 512,
    parameter int W      = 32,
    parameter bit IS_MAX = 1'b1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rmh_pkg::heap_cmd_t cmd,
    input  logic [W-1:0]      new_val,
    output logic [W-1:0]      top,
    output logic [CW-1:0]     count
);
    import rmh_pkg::*;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push_ok;
    logic [W-1:0]  vals [DEPTH];
    logic          inss [DEPTH];

    // Drop pushes into a full chain
    assign push_ok = cmd.push && (count_reg < CW'(DEPTH));

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [W-1:0] pv;
            logic         pi;
            logic [W-1:0] nv;
            if (i == 0)
            begin : g_first
                assign pv = new_val;
                assign pi = 1'b0;
            end
            else
            begin : g_mid
                assign pv = vals[i-1];
                assign pi = inss[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign nv = vals[i];
            end
            else
            begin : g_body
                assign nv = vals[i+1];
            end
            rmh_cell #(
                .W      (W),
                .IS_MAX (IS_MAX)
            ) u_cell (
                .clk      (clk),
                .push     (push_ok),
                .pop      (cmd.pop),
                .occupied (CW'(i) < count_reg),
                .new_val  (new_val),
                .prev_val (pv),
                .prev_ins (pi),
                .next_val (nv),
                .val      (vals[i]),
                .ins      (inss[i])
            );
        end
    endgenerate

    // Track the fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.pop && count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (push_ok)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top   = vals[0];
    assign count = count_reg;

endmodule

[src/running_median_two_heaps.sv]
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Streaming running median over a lower max chain and an upper min chain.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_ready | sample
// result  | out       | out_valid/out_ready | median_twice, sample_count, overflow
//
// An item runs the same steps whether or not a top moves across: accept,
// decide (and pop the moving top), insert, median update. A dropped item skips
// the insert.
// Reset clears the chain counts, the median and the control; chain slots are
// left unset. A stalled result sits in the output register while the next
// item is accepted and worked; it waits only before its own median update.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
    parameter int HEAP_DEPTH  = rmh_pkg::HEAP_DEPTH_DEF,
    parameter int SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF,
    localparam int SCW        = $clog2(2 * HEAP_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS:0]   median_twice,
    output logic [SCW-1:0]         sample_count,
    output logic                   overflow
);
    import rmh_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;
    localparam logic [1:0] S_MED  = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] t_reg, t_next;
    logic         mv_reg, mv_next;
    logic         tolo_reg, tolo_next;
    logic         drop_reg, drop_next;
    logic [W:0]   med_reg, med_next;
    logic         ov_reg, ov_next;
    logic [W:0]   mo_reg, mo_next;
    logic [SCW-1:0] cnt_reg, cnt_next;
    logic         oflag_reg, oflag_next;

    heap_cmd_t    lo_cmd, up_cmd;
    logic [W-1:0] lo_val, up_val, lo_top, up_top;
    logic [CW-1:0] lo_cnt, up_cnt;
    logic [W+1:0] x2, m_ext;
    logic         lt, gt;
    logic [W:0]   med_calc;
    logic         out_free;

    rmh_heap #(.DEPTH(HEAP_DEPTH), .W(W), .IS_MAX(1'b1)) u_lower (
        .clk(clk), .rst_n(rst_n), .cmd(lo_cmd), .new_val(lo_val),
        .top(lo_top), .count(lo_cnt)
    );

    rmh_heap #(.DEPTH(HEAP_DEPTH), .W(W), .IS_MAX(1'b0)) u_upper (
        .clk(clk), .rst_n(rst_n), .cmd(up_cmd), .new_val(up_val),
        .top(up_top), .count(up_cnt)
    );

    // Compare twice the sample against the stored median
    assign x2    = {x_reg[W-1], x_reg, 1'b0};
    assign m_ext = {med_reg[W], med_reg};
    assign lt    = $signed(x2) < $signed(m_ext);
    assign gt    = $signed(x2) > $signed(m_ext);

    // Median from the chain tops after the insert
    always_comb
    begin
        if (lo_cnt == up_cnt)
        begin
            med_calc = {lo_top[W-1], lo_top} + {up_top[W-1], up_top};
        end
        else if (lo_cnt > up_cnt)
        begin
            med_calc = {lo_top, 1'b0};
        end
        else
        begin
            med_calc = {up_top, 1'b0};
        end
    end

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign lo_val   = tolo_reg ? x_reg : t_reg;
    assign up_val   = tolo_reg ? t_reg : x_reg;

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        t_next     = t_reg;
        mv_next    = mv_reg;
        tolo_next  = tolo_reg;
        drop_next  = drop_reg;
        med_next   = med_reg;
        ov_next    = ov_reg;
        mo_next    = mo_reg;
        cnt_next   = cnt_reg;
        oflag_next = oflag_reg;
        lo_cmd     = '0;
        up_cmd     = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                mv_next    = 1'b0;
                drop_next  = 1'b0;
                state_next = S_PUSH;
                if (lo_cnt > up_cnt)
                begin
                    tolo_next = lt;
                    if (lt)
                    begin
                        mv_next = 1'b1;
                        t_next  = lo_top;
                        lo_cmd.pop = 1'b1;
                    end
                end
                else if (lo_cnt == up_cnt)
                begin
                    tolo_next = lt;
                    if (lo_cnt == CW'(HEAP_DEPTH))
                    begin
                        drop_next  = 1'b1;
                        state_next = S_MED;
                    end
                end
                else
                begin
                    tolo_next = !gt;
                    if (gt)
                    begin
                        mv_next = 1'b1;
                        t_next  = up_top;
                        up_cmd.pop = 1'b1;
                    end
                end
            end
            S_PUSH:
            begin
                lo_cmd.push = tolo_reg || mv_reg;
                up_cmd.push = !tolo_reg || mv_reg;
                state_next  = S_MED;
            end
            S_MED:
            begin
                if (out_free)
                begin
                    if (!drop_reg)
                    begin
                        med_next = med_calc;
                    end
                    mo_next    = drop_reg ? med_reg : med_calc;
                    cnt_next   = SCW'(lo_cnt) + SCW'(up_cnt);
                    oflag_next = drop_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and median state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            med_reg   <= '0;
            ov_reg    <= 1'b0;
            mv_reg    <= 1'b0;
            tolo_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            med_reg   <= med_next;
            ov_reg    <= ov_next;
            mv_reg    <= mv_next;
            tolo_reg  <= tolo_next;
            drop_reg  <= drop_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        t_reg     <= t_next;
        mo_reg    <= mo_next;
        cnt_reg   <= cnt_next;
        oflag_reg <= oflag_next;
    end

    assign out_valid    = ov_reg;
    assign median_twice = mo_reg;
    assign sample_count = cnt_reg;
    assign overflow     = oflag_reg;

    // Dropped item only with both chains full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> sample_count == SCW'(2 * HEAP_DEPTH))
        else $error("overflow without full chains");

    // Chain sizes stay balanced between items
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (lo_cnt == up_cnt) || (lo_cnt == up_cnt + 1'b1)
                                || (up_cnt == lo_cnt + 1'b1))
        else $error("chain sizes out of balance");

    // Moving a top is always followed by the insert step
    a_move_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (lo_cmd.pop || up_cmd.pop) |=> state_reg == S_PUSH && mv_reg)
        else $error("pop not followed by insert");

    // Never pop and push the same chain at once
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(lo_cmd.pop && lo_cmd.push) && !(up_cmd.pop && up_cmd.push))
        else $error("conflicting chain commands");

endmodule
